// ----- hdl/rc4a_pkg.sv -----
// rc4a_pkg: shared types, codes and constants for the rc4a stream cipher
// used by rc4a_ctrl, rc4a_dp and rc4a_stream_cipher; no dependencies
package rc4a_pkg;

    // memory geometry and field widths
    localparam int SBOX_DEPTH = 256;
    localparam int ADDR_W     = $clog2(SBOX_DEPTH);
    localparam int BYTE_W     = 8;
    localparam int OP_W       = 2;
    localparam int KLEN_W     = 9;

    // key length limits and reset value
    localparam logic [KLEN_W-1:0] KEY_LEN_RESET = 9'd16;
    localparam logic [KLEN_W-1:0] KEY_LEN_MIN   = 9'd1;
    localparam logic [KLEN_W-1:0] KEY_LEN_MAX   = 9'd256;

    // request opcodes
    localparam logic [OP_W-1:0] OP_KEY_WR = 2'd0;
    localparam logic [OP_W-1:0] OP_SCHED  = 2'd1;
    localparam logic [OP_W-1:0] OP_CRYPT  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // result status codes
    localparam logic STAT_OK        = 1'b0;
    localparam logic STAT_NOT_KEYED = 1'b1;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEYWR,
        ST_INIT,
        ST_KS0,
        ST_KS1,
        ST_KS2,
        ST_KS3,
        ST_CR1,
        ST_CR2,
        ST_CR3,
        ST_PASS
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic latch;       // capture the request payload
        logic key_wr;      // write key byte into key store
        logic init_wr;     // identity fill of both s-boxes
        logic ks_rd_n;     // schedule: read s[n] and key byte
        logic ks_rd_acc;   // schedule: update acc, read s[acc]
        logic ks_wr_n;     // schedule: s[n] <= s[acc]
        logic ks_wr_acc;   // schedule: s[acc] <= old s[n], advance n
        logic sched_done;  // schedule complete, clear indices
        logic cr_rd_i;     // crypt: step i in phase 0, read adv[i]
        logic cr_rd_j;     // crypt: update j, read adv[j]
        logic cr_wr_i;     // crypt: adv[i] <= adv[j], read look[sum]
        logic cr_wr_j;     // crypt: adv[j] <= old adv[i]
        logic cr_done;     // crypt: load result, flip phase
        logic pass_out;    // not keyed: load input byte unchanged
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic keyed;
        logic cnt_last;
        logic out_free;
    } t_stat;

endpackage

// ----- hdl/rc4a_ctrl.sv -----
// rc4a_ctrl: request sequencer for the rc4a stream cipher
// depends on rc4a_pkg; drives rc4a_dp through t_cmd and reads t_stat
module rc4a_ctrl
    import rc4a_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic [OP_W-1:0] i_req_op,
    input  t_stat           i_stat,
    output logic            o_req_ready,
    output t_cmd            o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    unique case (i_req_op)
                        OP_KEY_WR: n_state = ST_KEYWR;
                        OP_SCHED:  n_state = ST_INIT;
                        OP_CRYPT:  n_state = i_stat.keyed ? ST_CR1 : ST_PASS;
                        OP_NONE:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_KEYWR: n_state = ST_IDLE;
            ST_INIT:  n_state = i_stat.cnt_last ? ST_KS0 : ST_INIT;
            ST_KS0:   n_state = ST_KS1;
            ST_KS1:   n_state = ST_KS2;
            ST_KS2:   n_state = ST_KS3;
            ST_KS3:   n_state = i_stat.cnt_last ? ST_IDLE : ST_KS0;
            ST_CR1:   n_state = ST_CR2;
            ST_CR2:   n_state = ST_CR3;
            ST_CR3:   n_state = i_stat.out_free ? ST_IDLE : ST_CR3;
            ST_PASS:  n_state = i_stat.out_free ? ST_IDLE : ST_PASS;
            default:  n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.latch = i_req_valid;
                // first crypt read overlaps the accept cycle
                o_cmd.cr_rd_i = i_req_valid && (i_req_op == OP_CRYPT) && i_stat.keyed;
            end
            ST_KEYWR: o_cmd.key_wr  = 1'b1;
            ST_INIT:  o_cmd.init_wr = 1'b1;
            ST_KS0:   o_cmd.ks_rd_n = 1'b1;
            ST_KS1:   o_cmd.ks_rd_acc = 1'b1;
            ST_KS2:   o_cmd.ks_wr_n = 1'b1;
            ST_KS3: begin
                o_cmd.ks_wr_acc  = 1'b1;
                o_cmd.sched_done = i_stat.cnt_last;
            end
            ST_CR1:   o_cmd.cr_rd_j = 1'b1;
            ST_CR2:   o_cmd.cr_wr_i = 1'b1;
            ST_CR3: begin
                o_cmd.cr_wr_j = 1'b1;
                o_cmd.cr_done = i_stat.out_free;
            end
            ST_PASS:  o_cmd.pass_out = i_stat.out_free;
            default:  o_cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    // schedule ends only after the last swap
    a_sched_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sched_done |-> (r_state == ST_KS3) && i_stat.cnt_last)
        else $error("schedule finished before last index");

    // crypt step CR1 always leads straight to CR2
    a_cr_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CR1) |=> (r_state == ST_CR2))
        else $error("crypt sequence broken");

    // schedule loop entered only from fill or previous swap
    a_ks_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KS0) |-> $past(r_state == ST_INIT || r_state == ST_KS3))
        else $error("schedule loop entered from wrong state");
`endif

endmodule

// ----- hdl/rc4a_dp.sv -----
// rc4a_dp: key store, two s-box memories, indices and output register
// depends on rc4a_pkg; sequenced by rc4a_ctrl through t_cmd
module rc4a_dp
    import rc4a_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [ADDR_W-1:0] i_key_index,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_cfg_we,
    input  logic [KLEN_W-1:0] i_cfg_wdata,
    input  logic              i_out_ready,
    output t_stat             o_stat,
    output logic              o_out_valid,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_out_status
);

    // memories
    logic [BYTE_W-1:0] r_key_mem [SBOX_DEPTH];
    logic [BYTE_W-1:0] r_sbox1   [SBOX_DEPTH];
    logic [BYTE_W-1:0] r_sbox2   [SBOX_DEPTH];
    logic [BYTE_W-1:0] r_key_rd;
    logic [BYTE_W-1:0] r_s1_rd;
    logic [BYTE_W-1:0] r_s2_rd;

    // request payload and working registers
    logic [ADDR_W-1:0] r_in_kidx;
    logic [BYTE_W-1:0] r_in_data;
    logic [KLEN_W-1:0] r_key_len;
    logic [KLEN_W-1:0] r_len;
    logic [ADDR_W-1:0] r_cnt;
    logic [ADDR_W-1:0] r_kpos;
    logic [ADDR_W-1:0] r_acc;
    logic [BYTE_W-1:0] r_t;
    logic [ADDR_W-1:0] r_sum;
    logic [ADDR_W-1:0] r_i;
    logic [ADDR_W-1:0] r_j1;
    logic [ADDR_W-1:0] r_j2;
    logic              r_phase;
    logic              r_keyed;
    logic              r_ov;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_stat;

    logic [KLEN_W-1:0] n_len;
    logic [ADDR_W-1:0] n_kpos;
    logic [ADDR_W-1:0] n_acc;
    logic [ADDR_W-1:0] n_i;
    logic [ADDR_W-1:0] n_j;
    logic [ADDR_W-1:0] n_sum;

    logic [BYTE_W-1:0] rd_adv;
    logic [BYTE_W-1:0] rd_look;
    logic [ADDR_W-1:0] j_sel;
    logic              out_free;

    logic              crypt_op;
    logic [ADDR_W-1:0] adv_addr;
    logic              adv_we;
    logic [BYTE_W-1:0] adv_wd;
    logic [ADDR_W-1:0] look_addr;

    logic [ADDR_W-1:0] key_addr;
    logic [ADDR_W-1:0] s1_addr;
    logic              s1_we;
    logic [BYTE_W-1:0] s1_wd;
    logic [ADDR_W-1:0] s2_addr;
    logic              s2_we;
    logic [BYTE_W-1:0] s2_wd;

    // phase picks which box advances and which supplies the output
    assign rd_adv   = r_phase ? r_s2_rd : r_s1_rd;
    assign rd_look  = r_phase ? r_s1_rd : r_s2_rd;
    assign j_sel    = r_phase ? r_j2 : r_j1;
    assign out_free = !r_ov || i_out_ready;

    // index arithmetic mod 256; the key position wraps at the key length
    assign n_i   = r_phase ? r_i : r_i + 8'd1;
    assign n_j   = j_sel + rd_adv;
    assign n_acc = r_acc + r_s1_rd + r_key_rd;
    assign n_sum = r_t + rd_adv;
    assign n_kpos = ({1'b0, r_kpos} + 9'd1 == r_len) ? '0 : r_kpos + 8'd1;

    // key length clamped to 1..256
    always_comb begin
        priority if (r_key_len < KEY_LEN_MIN) begin
            n_len = KEY_LEN_MIN;
        end else if (r_key_len > KEY_LEN_MAX) begin
            n_len = KEY_LEN_MAX;
        end else begin
            n_len = r_key_len;
        end
    end

    // crypt port controls for advancing and output boxes
    always_comb begin
        crypt_op  = 1'b1;
        adv_addr  = r_i;
        adv_we    = 1'b0;
        adv_wd    = r_t;
        look_addr = r_sum;
        priority if (i_cmd.cr_rd_i) begin
            adv_addr = n_i;
        end else if (i_cmd.cr_rd_j) begin
            adv_addr = n_j;
        end else if (i_cmd.cr_wr_i) begin
            adv_addr  = r_i;
            adv_we    = 1'b1;
            adv_wd    = rd_adv;
            look_addr = n_sum;
        end else if (i_cmd.cr_wr_j) begin
            adv_addr = r_acc;
            adv_we   = 1'b1;
            adv_wd   = r_t;
        end else begin
            crypt_op = 1'b0;
        end
    end

    // s-box port muxing; the schedule writes both boxes alike
    always_comb begin
        s1_addr = r_cnt;
        s1_we   = 1'b0;
        s1_wd   = r_cnt;
        s2_addr = r_cnt;
        s2_we   = 1'b0;
        s2_wd   = r_cnt;
        priority if (i_cmd.init_wr) begin
            s1_we = 1'b1;
            s2_we = 1'b1;
        end else if (i_cmd.ks_rd_n) begin
            s1_addr = r_cnt;
        end else if (i_cmd.ks_rd_acc) begin
            s1_addr = n_acc;
        end else if (i_cmd.ks_wr_n) begin
            s1_we = 1'b1;
            s1_wd = r_s1_rd;
            s2_we = 1'b1;
            s2_wd = r_s1_rd;
        end else if (i_cmd.ks_wr_acc) begin
            s1_addr = r_acc;
            s1_we   = 1'b1;
            s1_wd   = r_t;
            s2_addr = r_acc;
            s2_we   = 1'b1;
            s2_wd   = r_t;
        end else if (crypt_op && !r_phase) begin
            s1_addr = adv_addr;
            s1_we   = adv_we;
            s1_wd   = adv_wd;
            s2_addr = look_addr;
        end else if (crypt_op) begin
            s2_addr = adv_addr;
            s2_we   = adv_we;
            s2_wd   = adv_wd;
            s1_addr = look_addr;
        end
    end

    assign key_addr = i_cmd.key_wr ? r_in_kidx : r_kpos;

    // key store memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_wr) begin
            r_key_mem[key_addr] <= r_in_data;
        end
        r_key_rd <= r_key_mem[key_addr];
    end

    // s-box one memory
    always_ff @(posedge i_clk) begin
        if (s1_we) begin
            r_sbox1[s1_addr] <= s1_wd;
        end
        r_s1_rd <= r_sbox1[s1_addr];
    end

    // s-box two memory
    always_ff @(posedge i_clk) begin
        if (s2_we) begin
            r_sbox2[s2_addr] <= s2_wd;
        end
        r_s2_rd <= r_sbox2[s2_addr];
    end

    // request payload and working values
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_in_kidx <= i_key_index;
            r_in_data <= i_data_byte;
        end
        if (i_cmd.ks_rd_acc) begin
            r_t   <= r_s1_rd;
        end else if (i_cmd.cr_rd_j) begin
            r_t   <= rd_adv;
        end
        if (i_cmd.cr_wr_i) begin
            r_sum <= n_sum;
        end
    end

    // schedule counters and key length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= KEY_LEN_RESET;
            r_len     <= KEY_LEN_RESET;
            r_cnt     <= '0;
            r_kpos    <= '0;
            r_acc     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_key_len <= i_cfg_wdata;
            end
            if (i_cmd.latch) begin
                r_len  <= n_len;
                r_cnt  <= '0;
                r_kpos <= '0;
                r_acc  <= '0;
            end else if (i_cmd.init_wr) begin
                r_cnt <= r_cnt + 8'd1;
            end else if (i_cmd.ks_rd_acc) begin
                r_acc <= n_acc;
            end else if (i_cmd.ks_wr_acc) begin
                r_cnt  <= r_cnt + 8'd1;
                r_kpos <= n_kpos;
            end else if (i_cmd.cr_rd_j) begin
                r_acc <= n_j;
            end
        end
    end

    // cipher indices, phase and keyed flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i     <= '0;
            r_j1    <= '0;
            r_j2    <= '0;
            r_phase <= 1'b0;
            r_keyed <= 1'b0;
        end else begin
            if (i_cmd.sched_done) begin
                r_i     <= '0;
                r_j1    <= '0;
                r_j2    <= '0;
                r_phase <= 1'b0;
                r_keyed <= 1'b1;
            end
            if (i_cmd.cr_rd_i) begin
                r_i <= n_i;
            end
            if (i_cmd.cr_rd_j && !r_phase) begin
                r_j1 <= n_j;
            end
            if (i_cmd.cr_rd_j && r_phase) begin
                r_j2 <= n_j;
            end
            if (i_cmd.cr_done) begin
                r_phase <= !r_phase;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.cr_done || i_cmd.pass_out) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cr_done) begin
            r_out_byte <= r_in_data ^ rd_look;
            r_out_stat <= STAT_OK;
        end else if (i_cmd.pass_out) begin
            r_out_byte <= r_in_data;
            r_out_stat <= STAT_NOT_KEYED;
        end
    end

    assign o_stat.keyed    = r_keyed;
    assign o_stat.cnt_last = (r_cnt == 8'hFF);
    assign o_stat.out_free = out_free;
    assign o_out_valid     = r_ov;
    assign o_out_byte      = r_out_byte;
    assign o_out_status    = r_out_stat;

`ifndef SYNTHESIS
    // a result is loaded only when the output register can take it
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cr_done || i_cmd.pass_out) |-> (!r_ov || i_out_ready))
        else $error("result loaded over a pending result");

    // keystream only after a schedule
    a_keyed_crypt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cr_rd_i |-> r_keyed)
        else $error("crypt started while not keyed");

    // phase only moves on a crypt result or schedule end
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != $past(r_phase)) |-> $past(i_cmd.cr_done || i_cmd.sched_done))
        else $error("phase changed without a crypt result");
`endif

endmodule

// ----- hdl/rc4a_stream_cipher.sv -----
// rc4a_stream_cipher: top level of the rc4a byte cipher
// depends on rc4a_pkg, rc4a_ctrl and rc4a_dp
//
// RC4A byte cipher with two 256-entry s-boxes. A request carries an opcode in
// s_axis_tuser: key byte write, key schedule, crypt byte, or none (ignored). A
// schedule runs one identity fill pass and then, per index, a read of s[n] and
// the key byte, a read of s[acc] and two swap writes, because every swap needs
// two dependent reads and two writes on the single-port s-box memory (both boxes
// are scheduled at once with the same key). A crypt byte runs the read of s[i],
// the dependent read of s[j] and the two swap writes on the advancing box; the
// output lookup in the other box overlaps the first write. A result waiting in
// the output register does not block key writes or a schedule. A crypt byte
// before the first schedule comes back unchanged with status 1.
// key_length (1..256, out-of-range values clamped) applies at the next schedule.
module rc4a_stream_cipher
    import rc4a_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // key_index[7:0], data_byte[15:8]
    input  logic [OP_W-1:0]   s_axis_tuser,   // opcode[1:0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // out_byte[7:0]
    output logic              m_axis_tuser,   // status[0]
    input  logic              i_cfg_we,
    input  logic [KLEN_W-1:0] i_cfg_wdata
);

    t_cmd  cmd;
    t_stat stat;

    // request sequencer
    rc4a_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_op    (s_axis_tuser),
        .i_stat      (stat),
        .o_req_ready (s_axis_tready),
        .o_cmd       (cmd)
    );

    // memories and cipher state
    rc4a_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_key_index  (s_axis_tdata[7:0]),
        .i_data_byte  (s_axis_tdata[15:8]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_ready  (m_axis_tready),
        .o_stat       (stat),
        .o_out_valid  (m_axis_tvalid),
        .o_out_byte   (m_axis_tdata),
        .o_out_status (m_axis_tuser)
    );

endmodule

// ----- dv/testbench.sv -----
// testbench: self-checking stream testbench for the rc4a byte cipher
// depends on rc4a_pkg and rc4a_stream_cipher; predicts each result in place
// and compares it field by field against the master stream
`timescale 1ns / 100ps

module testbench;
    import rc4a_pkg::*;

    // drain time that covers a key schedule or any other work still in flight
    localparam int DRAIN_CYCLES = 1500;
    localparam int STALL_LIMIT  = 20000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_REQS   = 140;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] kidx;
        logic [BYTE_W-1:0] data;
    } t_cipher_req;

    typedef struct packed {
        logic [BYTE_W-1:0] text;
        logic              status;
    } t_cipher_res;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata  = '0;
    logic [OP_W-1:0]   s_axis_tuser  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [BYTE_W-1:0] m_axis_tdata;
    logic              m_axis_tuser;
    logic              i_cfg_we      = 1'b0;
    logic [KLEN_W-1:0] i_cfg_wdata   = '0;

    always #5 i_clk = ~i_clk;

    rc4a_stream_cipher u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // predicted cipher state
    bit [7:0]          key_mem [SBOX_DEPTH];
    bit [7:0]          sbox    [2][SBOX_DEPTH];
    bit [7:0]          pos_i;
    bit [7:0]          pos_j   [2];
    bit                half_sel;
    bit                keyed;
    bit [KLEN_W-1:0]   key_len_reg = KEY_LEN_RESET;

    t_cipher_req       req_q[$];
    t_cipher_res       cipher_out_q[$];
    bit                key_written [SBOX_DEPTH];
    bit                tight_flow = 1'b0;
    int                err_count  = 0;

    // key length as the schedule uses it
    function automatic int eff_key_len(input bit [KLEN_W-1:0] v);
        if (v < KEY_LEN_MIN)
            return int'(KEY_LEN_MIN);
        if (v > KEY_LEN_MAX)
            return int'(KEY_LEN_MAX);
        return int'(v);
    endfunction

    // advance the predicted state by one accepted request
    task automatic cipher_model(input t_cipher_req r);
        int          len;
        int          a;
        bit [7:0]    acc;
        bit [7:0]    t;
        t_cipher_res res;
        case (r.op)
            OP_KEY_WR: begin
                key_mem[r.kidx] = r.data;
            end
            OP_SCHED: begin
                len = eff_key_len(key_len_reg);
                for (int n = 0; n < SBOX_DEPTH; n++)
                    sbox[0][n] = n[7:0];
                acc = '0;
                for (int n = 0; n < SBOX_DEPTH; n++) begin
                    acc = acc + sbox[0][n] + key_mem[n % len];
                    t = sbox[0][n];
                    sbox[0][n] = sbox[0][acc];
                    sbox[0][acc] = t;
                end
                // both boxes get the same key
                for (int n = 0; n < SBOX_DEPTH; n++)
                    sbox[1][n] = sbox[0][n];
                pos_i = '0;
                pos_j[0] = '0;
                pos_j[1] = '0;
                half_sel = 1'b0;
                keyed = 1'b1;
            end
            OP_CRYPT: begin
                if (!keyed) begin
                    res.text = r.data;
                    res.status = STAT_NOT_KEYED;
                end else begin
                    // phase 0 steps i and advances box one, phase 1 box two
                    a = half_sel ? 1 : 0;
                    if (!half_sel)
                        pos_i = pos_i + 8'd1;
                    pos_j[a] = pos_j[a] + sbox[a][pos_i];
                    t = sbox[a][pos_i];
                    sbox[a][pos_i] = sbox[a][pos_j[a]];
                    sbox[a][pos_j[a]] = t;
                    t = sbox[a][pos_i] + sbox[a][pos_j[a]];
                    res.text = r.data ^ sbox[1 - a][t];
                    res.status = STAT_OK;
                    half_sel = ~half_sel;
                end
                cipher_out_q.push_back(res);
            end
            default: ;
        endcase
    endtask

    // request driver
    int          send_gap = 0;
    t_cipher_req cur_req;
    always @(posedge i_clk) begin
        logic next_valid;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                cipher_model(cur_req);
                send_gap = tight_flow ? 0 : $urandom_range(0, 9);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (req_q.size() > 0) begin
                    cur_req = req_q.pop_front();
                    s_axis_tdata <= {cur_req.data, cur_req.kidx};
                    s_axis_tuser <= cur_req.op;
                    next_valid = 1'b1;
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // result monitor and checker
    int recv_gap = 0;
    always @(posedge i_clk) begin
        t_cipher_res want;
        logic        next_ready;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            next_ready = m_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                if (cipher_out_q.size() == 0) begin
                    $error("unexpected result: out_byte %02h status %0d",
                           m_axis_tdata, m_axis_tuser);
                    err_count++;
                end else begin
                    want = cipher_out_q.pop_front();
                    if (m_axis_tdata !== want.text) begin
                        $error("out_byte: expected %02h, actual %02h", want.text, m_axis_tdata);
                        err_count++;
                    end
                    if (m_axis_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
                        err_count++;
                    end
                end
                recv_gap = tight_flow ? 0 : $urandom_range(0, 9);
                next_ready = 1'b0;
            end
            if (!next_ready) begin
                if (recv_gap > 0)
                    recv_gap--;
                else
                    next_ready = 1'b1;
            end
            m_axis_tready <= next_ready;
        end
    end

    // watchdog on cycles without any handshake
    int stall_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_req(input logic [OP_W-1:0] op, input int kidx, input int data);
        t_cipher_req r;
        r.op = op;
        r.kidx = kidx[ADDR_W-1:0];
        r.data = data[BYTE_W-1:0];
        if (op == OP_KEY_WR)
            key_written[r.kidx] = 1'b1;
        req_q.push_back(r);
    endtask

    // schedule request, preceded by writes of any key byte it would read unwritten
    task automatic queue_schedule();
        int len;
        len = eff_key_len(key_len_reg);
        for (int n = 0; n < len; n++)
            if (!key_written[n])
                queue_req(OP_KEY_WR, n, $urandom_range(0, 255));
        queue_req(OP_SCHED, $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    // hold off until every request is sent and every result is back
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (req_q.size() != 0 || s_axis_tvalid || cipher_out_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_key_len(input bit [KLEN_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        key_len_reg = v;
    endtask

    // stimulus
    initial begin
        int cfg_plan [RAND_PHASES];
        int pick;
        int sent;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: crypt before keying, ignored opcode, key load at reset length, schedule and crypt
        queue_req(OP_CRYPT, 8'h00, 8'h00);
        queue_req(OP_CRYPT, 8'hFF, 8'hFF);
        queue_req(OP_NONE, 8'hFF, 8'hFF);
        for (int k = 0; k < 16; k++)
            queue_req(OP_KEY_WR, k, (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : $urandom_range(0, 255));
        queue_req(OP_KEY_WR, 8'hFF, 8'hA5);
        queue_req(OP_SCHED, 8'h00, 8'h00);
        queue_req(OP_CRYPT, 8'h00, 8'h00);
        queue_req(OP_CRYPT, 8'hFF, 8'hFF);
        queue_req(OP_CRYPT, 8'h5A, 8'h5A);
        queue_req(OP_CRYPT, 8'hA5, 8'hA5);
        wait_drained();

        // random phases, one key length each, extremes and out-of-range first
        cfg_plan = '{1, 256, 0, 511, 300, 2, $urandom_range(1, 256), $urandom_range(0, 511)};
        for (int p = 0; p < RAND_PHASES; p++) begin
            tight_flow = (p % 3 == 1);
            write_key_len(cfg_plan[p][KLEN_W-1:0]);
            // old key stays in use until the next schedule
            for (int k = 0; k < 6; k++)
                queue_req(OP_CRYPT, $urandom_range(0, 255), $urandom_range(0, 255));
            queue_schedule();
            sent = 7;
            while (sent < PHASE_REQS) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    queue_req(OP_CRYPT, $urandom_range(0, 255), $urandom_range(0, 255));
                    sent++;
                end else if (pick < 80) begin
                    queue_req(OP_KEY_WR, $urandom_range(0, 255), $urandom_range(0, 255));
                    sent++;
                end else if (pick < 86) begin
                    // rewrite a byte the next schedule will read
                    queue_req(OP_KEY_WR, $urandom_range(0, eff_key_len(key_len_reg) - 1),
                              $urandom_range(0, 255));
                    sent++;
                end else if (pick < 91) begin
                    queue_schedule();
                    sent++;
                end else if (pick < 95) begin
                    queue_req(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 255));
                end else begin
                    for (int k = 0; k < 8; k++)
                        queue_req(OP_CRYPT, $urandom_range(0, 255), $urandom_range(0, 255));
                    sent += 8;
                end
            end
            wait_drained();
        end

        if (cipher_out_q.size() != 0) begin
            $error("%0d results never arrived", cipher_out_q.size());
            err_count++;
        end
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
